@@ hw/rtl/s2cd_pkg.sv @@
// Shared types, constants and the month length function for the seconds to date converter.
`timescale 1ns / 1ps

package s2cd_pkg;

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;
    localparam int unsigned DaysPerQuad = 3 * 365 + 366;
    localparam int unsigned DaysLeap    = 366;
    localparam int unsigned DaysCommon  = 365;
    localparam int unsigned FirstBadSec = 32'd3155760000;

    localparam int unsigned WordW = 32;

    localparam logic [3:0] MonthFeb  = 4'd2;
    localparam logic [3:0] MonthApr  = 4'd4;
    localparam logic [3:0] MonthJun  = 4'd6;
    localparam logic [3:0] MonthSep  = 4'd9;
    localparam logic [3:0] MonthNov  = 4'd11;
    localparam logic [3:0] MonthLast = 4'd12;

    typedef struct packed {
        logic       out_of_range;
        logic [5:0] second_of_minute;
        logic [5:0] minute_of_hour;
        logic [4:0] hour_of_day;
        logic [4:0] day_of_month;
        logic [3:0] month_number;
        logic [6:0] year_of_century;
    } t_result;

    // Every year divisible by four is a leap year over 2000 to 2099.
    function automatic logic [4:0] month_length(input logic [3:0] month,
                                                input logic       leap);
        logic [4:0] len;
        len = 5'd31;
        if (month == MonthApr || month == MonthJun || month == MonthSep ||
            month == MonthNov) begin
            len = 5'd30;
        end else if (month == MonthFeb) begin
            len = leap ? 5'd29 : 5'd28;
        end
        return len;
    endfunction

endpackage

@@ hw/rtl/s2cd_sub_unit.sv @@
// Shared compare and subtract unit used by every step of the conversion.
`timescale 1ns / 1ps

module s2cd_sub_unit
    import s2cd_pkg::*;
(
    input  logic [WordW-1:0] i_a,
    input  logic [WordW-1:0] i_b,
    output logic [WordW-1:0] o_diff,
    output logic             o_ge
);

    logic [WordW:0] w_wide;

    assign w_wide = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_wide[WordW-1:0];
    assign o_ge   = ~w_wide[WordW];

endmodule

@@ hw/rtl/s2cd_seq.sv @@
// Sequencer that runs the restoring divisions, year steps and month walk.
`timescale 1ns / 1ps

module s2cd_seq
    import s2cd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_secs,
    output logic        o_idle,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_result     o_res
);

    typedef enum logic [2:0] {
        S_IDLE, S_DAY, S_QUAD, S_YEAR, S_MONTH, S_HOUR, S_MIN, S_DONE
    } t_state;

    t_state           r_state;
    logic [WordW-1:0] r_rem;
    logic [15:0]      r_quo;
    logic [3:0]       r_cnt;
    logic [16:0]      r_tod;
    t_result          r_res;

    logic [WordW-1:0] w_a;
    logic [WordW-1:0] w_b;
    logic [WordW-1:0] w_diff;
    logic             w_ge;
    logic [15:0]      n_quo;
    logic [WordW-1:0] n_rem;

    s2cd_sub_unit u_sub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    // Operand selection for the shared unit; divisions shift the divisor down a bit a cycle.
    always_comb begin
        w_a = r_rem;
        w_b = '0;
        unique case (r_state)
            S_IDLE: begin
                w_a = i_secs;
                w_b = WordW'(FirstBadSec);
            end
            S_DAY:   w_b = WordW'(SecsPerDay) << r_cnt;
            S_QUAD:  w_b = WordW'(DaysPerQuad) << r_cnt;
            S_YEAR:  w_b = (r_cnt == 4'd0) ? WordW'(DaysLeap) : WordW'(DaysCommon);
            S_MONTH: w_b = WordW'(month_length(r_res.month_number,
                                               r_res.year_of_century[1:0] == 2'd0));
            S_HOUR:  w_b = WordW'(SecsPerHour) << r_cnt;
            S_MIN:   w_b = WordW'(SecsPerMin) << r_cnt;
            S_DONE:  w_b = '0;
            default: w_b = '0;
        endcase
    end

    always_comb begin
        n_quo = r_quo;
        n_quo[r_cnt] = w_ge;
        n_rem = w_ge ? w_diff : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_res <= '0;
                        r_rem <= i_secs;
                        r_quo <= '0;
                        r_cnt <= 4'd15;
                        if (w_ge) begin
                            r_res.out_of_range <= 1'b1;
                            r_state            <= S_DONE;
                        end else begin
                            r_state <= S_DAY;
                        end
                    end
                end
                S_DAY: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_tod   <= n_rem[16:0];
                        r_rem   <= {16'd0, n_quo};
                        r_quo   <= '0;
                        r_cnt   <= 4'd4;
                        r_state <= S_QUAD;
                    end
                end
                S_QUAD: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_res.year_of_century <= {n_quo[4:0], 2'b00};
                        r_cnt                 <= '0;
                        r_state               <= S_YEAR;
                    end
                end
                S_YEAR: begin
                    if (w_ge) begin
                        r_rem                 <= w_diff;
                        r_res.year_of_century <= r_res.year_of_century + 7'd1;
                        r_cnt                 <= r_cnt + 4'd1;
                    end
                    if (!w_ge || r_cnt == 4'd2) begin
                        r_res.month_number <= 4'd1;
                        r_state            <= S_MONTH;
                    end
                end
                S_MONTH: begin
                    if (r_res.month_number != MonthLast && w_ge) begin
                        r_rem              <= w_diff;
                        r_res.month_number <= r_res.month_number + 4'd1;
                    end else begin
                        r_res.day_of_month <= r_rem[4:0] + 5'd1;
                        r_rem              <= {15'd0, r_tod};
                        r_quo              <= '0;
                        r_cnt              <= 4'd4;
                        r_state            <= S_HOUR;
                    end
                end
                S_HOUR: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_res.hour_of_day <= n_quo[4:0];
                        r_quo             <= '0;
                        r_cnt             <= 4'd5;
                        r_state           <= S_MIN;
                    end
                end
                S_MIN: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_res.minute_of_hour   <= n_quo[5:0];
                        r_res.second_of_minute <= n_rem[5:0];
                        r_state                <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

@@ hw/rtl/seconds_to_calendar_date.sv @@
// Top level of the seconds to calendar date converter with its output register.
`timescale 1ns / 1ps
// Converts a count of seconds since 2000-01-01 00:00:00 into year of century,
// month, day, hour, minute and second, valid for 2000 to 2099.
// The slave stream takes one 32-bit second count per transaction; the master
// stream returns one result transaction per input. Inputs past the end of
// 2099 return out_of_range set and all other fields zero.
// One compare and subtract unit does all the work for an input, one quotient
// bit, year step or month step per cycle (16 quotient bits for days, 5 for
// four-year periods, up to 3 year steps, up to 12 month steps, 5 bits for
// hours and 6 for minutes). Out-of-range inputs skip these steps and go
// straight to the result.
// The slave side is ready only while the sequencer is idle. A finished result
// moves into the output register, so a new input is taken while it waits.
// If the receiver stalls, the next result holds in the sequencer and no
// further input is taken until the output register frees up.
// Reset clears the sequencer and the output valid flag; an input in flight
// and a result not yet taken are lost.

module seconds_to_calendar_date
    import s2cd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] seconds_since_2000
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [6:0] year_of_century, [10:7] month_number, [15:11] day_of_month,
    // [20:16] hour_of_day, [26:21] minute_of_hour, [32:27] second_of_minute,
    // [33] out_of_range, [39:34] zero
    output logic [39:0] o_m_axis_tdata
);

    logic    w_idle;
    logic    w_res_valid;
    logic    w_res_ready;
    t_result w_res;

    logic    r_out_valid;
    t_result r_out;

    assign o_s_axis_tready = w_idle;
    assign w_res_ready     = !r_out_valid || i_m_axis_tready;

    s2cd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_s_axis_tvalid),
        .i_secs      (i_s_axis_tdata),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_res_ready) begin
                r_out_valid <= w_res_valid;
            end
        end
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out};

endmodule

@@ test/tb_seconds_to_calendar_date.sv @@
// Self-checking testbench for the seconds to calendar date converter.
`timescale 1ns / 1ps

module tb_seconds_to_calendar_date
    import s2cd_pkg::*;
();

    localparam int unsigned IdleLimit   = 4000;
    localparam int unsigned SettleTicks = 80;

    typedef struct {
        logic [31:0] secs;
        t_result     date;
    } t_pending_date;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [31:0] seconds_since_2000
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // [6:0] year, [10:7] month, [15:11] day, [20:16] hour, [26:21] minute,
    // [32:27] second, [33] out_of_range, [39:34] zero
    logic [39:0] o_m_axis_tdata;

    t_pending_date pending_dates[$];
    int unsigned   error_count;
    int unsigned   sent_count;
    int unsigned   checked_count;
    int unsigned   beyond_2099_count;
    int unsigned   burst_left;
    int unsigned   send_gap_max;
    int unsigned   ready_stall_max;
    int unsigned   ready_hold;
    int unsigned   idle_ticks;

    seconds_to_calendar_date uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned days_in_month(input int unsigned mon, input bit leap);
        case (mon)
            MonthApr, MonthJun, MonthSep, MonthNov: days_in_month = 30;
            MonthFeb: days_in_month = leap ? 29 : 28;
            default: days_in_month = 31;
        endcase
    endfunction

    // Day of year on which the given month begins.
    function automatic int unsigned month_start(input int unsigned mon, input bit leap);
        int unsigned acc;
        acc = 0;
        for (int unsigned m = 1; m < mon; m++) begin
            acc += days_in_month(m, leap);
        end
        return acc;
    endfunction

    function automatic logic [31:0] seconds_of(input int unsigned yr, input int unsigned doy,
                                               input int unsigned sod);
        int unsigned days;
        days = yr * DaysCommon + (yr + 3) / 4 + doy;
        return days * SecsPerDay + sod;
    endfunction

    function automatic t_result calendar_of(input logic [31:0] secs);
        t_result     r;
        int unsigned day_idx;
        int unsigned sod;
        int unsigned yr;
        int unsigned mon;
        r = '0;
        if (secs >= FirstBadSec) begin
            r.out_of_range = 1'b1;
            return r;
        end
        day_idx = secs / SecsPerDay;
        sod     = secs % SecsPerDay;
        yr      = (day_idx / DaysPerQuad) * 4;
        day_idx = day_idx % DaysPerQuad;
        // The leap year opens each four-year period; the last day of a year
        // must not spill into the next one.
        if (day_idx >= DaysLeap) begin
            yr++;
            day_idx -= DaysLeap;
            if (day_idx >= DaysCommon) begin
                yr++;
                day_idx -= DaysCommon;
                if (day_idx >= DaysCommon) begin
                    yr++;
                    day_idx -= DaysCommon;
                end
            end
        end
        mon = 1;
        while (mon < MonthLast && day_idx >= days_in_month(mon, (yr % 4) == 0)) begin
            day_idx -= days_in_month(mon, (yr % 4) == 0);
            mon++;
        end
        r.year_of_century  = yr[6:0];
        r.month_number     = mon[3:0];
        r.day_of_month     = 5'(day_idx + 1);
        r.hour_of_day      = 5'(sod / SecsPerHour);
        r.minute_of_hour   = 6'((sod % SecsPerHour) / SecsPerMin);
        r.second_of_minute = 6'(sod % SecsPerMin);
        return r;
    endfunction

    task automatic send_seconds(input logic [31:0] secs);
        int unsigned gap;
        t_pending_date entry;
        if (burst_left == 0) begin
            if (send_gap_max != 0) begin
                gap = $urandom_range(0, send_gap_max);
                if (gap != 0) begin
                    @(negedge i_clk);
                    i_s_axis_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= secs;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        entry.secs = secs;
        entry.date = calendar_of(secs);
        pending_dates.push_back(entry);
        sent_count++;
        burst_left--;
    endtask

    // Stops sending and waits until every outstanding conversion has returned.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_time_of_day();
        send_gap_max    = 0;
        ready_stall_max = 0;
        send_seconds(32'd0);
        send_seconds(32'd59);
        send_seconds(32'd60);
        send_seconds(32'd3599);
        send_seconds(32'd3600);
        send_seconds(32'd86399);
        send_seconds(32'd86400);
    endtask

    task automatic test_year_and_leap_edges();
        send_gap_max    = 3;
        ready_stall_max = 4;
        send_seconds(seconds_of(0, 58, 0));
        send_seconds(seconds_of(0, 59, 43200));
        send_seconds(seconds_of(0, 60, 0));
        send_seconds(seconds_of(1, 58, 86399));
        send_seconds(seconds_of(1, 59, 0));
        send_seconds(seconds_of(0, 365, 86399));
        send_seconds(seconds_of(1, 0, 0));
        send_seconds(seconds_of(1, 364, 86399));
        send_seconds(seconds_of(3, 364, 86399));
        send_seconds(seconds_of(4, 0, 0));
    endtask

    task automatic test_out_of_range();
        send_gap_max    = 0;
        ready_stall_max = 6;
        send_seconds(FirstBadSec - 1);
        send_seconds(FirstBadSec);
        send_seconds(32'hFFFF_FFFF);
        send_seconds(32'h8000_0000);
        drain_results();
    endtask

    task automatic test_month_edges(input int unsigned count);
        int unsigned yr;
        int unsigned mon;
        int unsigned first;
        send_gap_max    = 5;
        ready_stall_max = 6;
        for (int unsigned n = 0; n < count; n++) begin
            yr    = $urandom_range(0, 99);
            mon   = $urandom_range(1, 12);
            first = month_start(mon, (yr % 4) == 0);
            if (n[0]) begin
                send_seconds(seconds_of(yr, first + days_in_month(mon, (yr % 4) == 0) - 1,
                                        $urandom_range(SecsPerDay - 60, SecsPerDay - 1)));
            end else begin
                send_seconds(seconds_of(yr, first, $urandom_range(0, 59)));
            end
        end
    endtask

    task automatic test_random_seconds(input int unsigned count);
        int unsigned pick;
        int unsigned yr;
        logic [31:0] secs;
        for (int unsigned n = 0; n < count; n++) begin
            // Change the traffic shape every quarter, with one quarter free of idling.
            if (n % 250 == 0) begin
                case ((n / 250) % 4)
                    0: begin send_gap_max = 0;  ready_stall_max = 0;  end
                    1: begin send_gap_max = 12; ready_stall_max = 2;  end
                    2: begin send_gap_max = 2;  ready_stall_max = 20; end
                    default: begin send_gap_max = 30; ready_stall_max = 10; end
                endcase
            end
            if (n == count / 2) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                secs = $urandom_range(0, FirstBadSec - 1);
            end else if (pick < 85) begin
                yr = $urandom_range(0, 99);
                case ($urandom_range(0, 3))
                    0: secs = seconds_of(yr, 0, $urandom_range(0, SecsPerDay - 1));
                    1: secs = seconds_of(yr, 58 + $urandom_range(0, 2), $urandom_range(0, 86399));
                    2: secs = seconds_of(yr, ((yr % 4) == 0) ? 365 : 364,
                                         $urandom_range(0, SecsPerDay - 1));
                    default: secs = seconds_of(yr, $urandom_range(0, 364), 86399);
                endcase
            end else if (pick < 93) begin
                secs = $urandom_range(FirstBadSec, 32'hFFFF_FFFF);
            end else begin
                secs = $urandom();
            end
            send_seconds(secs);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] secs,
                                 input int unsigned exp_val, input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: input %0d, %s expected %0d actual %0d",
                     $time, secs, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Receiver stall pattern: alternating ready and stalled stretches, or always ready when no stall is allowed.
    always @(negedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold--;
        end else if (ready_stall_max == 0) begin
            i_m_axis_tready <= 1'b1;
        end else if (i_m_axis_tready) begin
            i_m_axis_tready <= 1'b0;
            ready_hold = $urandom_range(0, ready_stall_max - 1);
        end else begin
            i_m_axis_tready <= 1'b1;
            ready_hold = $urandom_range(0, 8);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pending_date head;
        t_result       got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[33:0]);
            if (pending_dates.size() == 0) begin
                $display("%0t ns: result with nothing expected, expected none actual %h",
                         $time, o_m_axis_tdata);
                error_count++;
            end else begin
                head = pending_dates.pop_front();
                compare_field("year", head.secs, head.date.year_of_century,
                              got.year_of_century);
                compare_field("month", head.secs, head.date.month_number, got.month_number);
                compare_field("day", head.secs, head.date.day_of_month, got.day_of_month);
                compare_field("hour", head.secs, head.date.hour_of_day, got.hour_of_day);
                compare_field("minute", head.secs, head.date.minute_of_hour,
                              got.minute_of_hour);
                compare_field("second", head.secs, head.date.second_of_minute,
                              got.second_of_minute);
                compare_field("out_of_range", head.secs, head.date.out_of_range,
                              got.out_of_range);
                compare_field("padding", head.secs, 0, o_m_axis_tdata[39:34]);
                checked_count++;
                if (head.date.out_of_range) beyond_2099_count++;
            end
        end
    end

    // Ends the run if no transaction happens on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_ticks = 0;
        end else begin
            idle_ticks++;
            if (idle_ticks >= IdleLimit) begin
                $display("%0t ns: no transaction for %0d cycles", $time, IdleLimit);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        error_count     = 0;
        sent_count      = 0;
        checked_count   = 0;
        beyond_2099_count = 0;
        burst_left      = 0;
        send_gap_max    = 0;
        ready_stall_max = 0;
        ready_hold      = 0;
        idle_ticks      = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_time_of_day();
        test_year_and_leap_edges();
        test_out_of_range();
        test_month_edges(150);
        test_random_seconds(1000);

        drain_results();
        repeat (SettleTicks) @(posedge i_clk);
        if (pending_dates.size() != 0) begin
            $display("%0t ns: results missing, expected %0d more actual 0",
                     $time, pending_dates.size());
            error_count++;
        end
        $display("Sent %0d second counts, checked %0d dates, %0d of them past 2099.",
                 sent_count, checked_count, beyond_2099_count);
        $display("Covered time-of-day, leap, year and month edges with idling on both sides.");
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
